FILE: hdl/rudfp_pkg.sv
`default_nettype none
package rudfp_pkg;

  localparam int MAX_ACK_BYTES = 64;
  localparam int HEAD_BYTES    = 12;
  localparam int LEN_W         = 16;
  localparam int IDX_W         = $clog2(MAX_ACK_BYTES + 1);
  localparam int HEAD_IDX_W    = $clog2(HEAD_BYTES);
  localparam int NUM_PW        = 5;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int OUT_DATA_W = 144;

  localparam logic [7:0] T_HDR_BYTE  = 8'hAA;
  localparam logic [7:0] T_TAIL_BYTE = 8'h55;
  localparam logic [7:0] T_MAX_STATUS = 8'h02;
  localparam logic [15:0] MAX_DIST_RESET = 16'd800;

  localparam logic [7:0] A_HDR1 = 8'hFD;
  localparam logic [7:0] A_HDR2 = 8'hFC;
  localparam logic [7:0] A_HDR3 = 8'hFB;
  localparam logic [7:0] A_HDR4 = 8'hFA;
  localparam logic [7:0] A_TAIL1 = 8'h04;
  localparam logic [7:0] A_TAIL2 = 8'h03;
  localparam logic [7:0] A_TAIL3 = 8'h02;
  localparam logic [7:0] A_TAIL4 = 8'h01;

  localparam logic [15:0] ACK_CODE_VERSION  = 16'h0001;
  localparam logic [15:0] ACK_CODE_ENABLE   = 16'hFF01;
  localparam logic [15:0] ACK_CODE_END      = 16'hFE01;
  localparam logic [15:0] ACK_CODE_DISTANCE = 16'h6701;
  localparam logic [15:0] ACK_CODE_READ     = 16'h7301;

  localparam logic [2:0] KIND_TARGET     = 3'd0;
  localparam logic [2:0] KIND_BAD_STATUS = 3'd1;
  localparam logic [2:0] KIND_TOO_FAR    = 3'd2;
  localparam logic [2:0] KIND_DATA_TAIL  = 3'd3;
  localparam logic [2:0] KIND_ACK        = 3'd4;
  localparam logic [2:0] KIND_ACK_SHORT  = 3'd5;
  localparam logic [2:0] KIND_ACK_LONG   = 3'd6;
  localparam logic [2:0] KIND_ACK_TAIL   = 3'd7;

  localparam logic [2:0] CLS_VERSION   = 3'd0;
  localparam logic [2:0] CLS_ENABLE    = 3'd1;
  localparam logic [2:0] CLS_END       = 3'd2;
  localparam logic [2:0] CLS_DISTANCE  = 3'd3;
  localparam logic [2:0] CLS_READ      = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN   = 3'd5;
  localparam logic [2:0] CLS_NO_STATUS = 3'd6;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    last;
    logic [7:0]              target_state;
    logic [15:0]             target_range;
    logic [15:0]             ack_code;
    logic [LEN_W-1:0]        ack_length;
    logic [2:0]              ack_class;
    logic [NUM_PW-1:0][15:0] pw;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/radar_uart_dual_frame_parser_core.sv
// Radar UART frame parser.
// Input channel (in_*): one received serial byte per item in in_tdata.
// Every byte is fed to two recognizers: target frames AA AA status dist
// 55 55 and acknowledge frames FD FC FB FA len payload 04 03 02 01.
// Result channel (out_*): out_tuser carries the result kind, out_tlast marks
// the final result caused by one byte, out_tdata carries the report fields.
// A byte causes zero, one or two results; with two, the target result leaves
// first.
// An accepted byte is registered, parsed from that register, and its
// results are written into the queue, from which the output is read.
// Throughput: one byte per cycle while in_tready is high. Results wait in a
// four-entry queue; the input is ready while the queue plus the byte being
// parsed leave room for two more results, so a stalled receiver holds the
// input off after at most a few results and nothing is lost.
// cfg_wen writes the distance limit; write it only while the block is idle.
// Reset (synchronous, rst_n low) returns both recognizers to idle, empties
// the queue and sets the distance limit to 800 cm.
`default_nettype none
module radar_uart_dual_frame_parser_core
  import rudfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // target_state, target_range,
                                                 // ack_code, ack_length,
                                                 // ack_class, payload_word0..4
  output logic                       out_tlast,  // last
  output logic [2:0]                 out_tuser,  // kind
  input  wire logic                  cfg_wen,
  input  wire logic [15:0]           cfg_wdata   // max_distance_cm
);

  typedef enum logic [2:0] {
    TP_IDLE, TP_HDR2, TP_STATUS, TP_DLO, TP_DHI, TP_TAIL1, TP_TAIL2
  } tphase_t;

  typedef enum logic [3:0] {
    AP_IDLE, AP_HDR2, AP_HDR3, AP_HDR4, AP_LENL, AP_LENH, AP_DATA,
    AP_TAIL1, AP_TAIL2, AP_TAIL3, AP_TAIL4
  } aphase_t;

  logic [7:0]       in_byte_r;
  logic             in_vld_r;
  logic [15:0]      max_dist_r;

  tphase_t          tphase_r, tphase_nxt;
  aphase_t          aphase_r, aphase_nxt;
  logic [7:0]       held_status_r, held_status_nxt;
  logic [15:0]      held_dist_r, held_dist_nxt;
  logic [LEN_W-1:0] ack_len_r, ack_len_nxt;
  logic [IDX_W-1:0] ack_idx_r, ack_idx_nxt;
  logic [IDX_W-1:0] idx_inc;
  logic [LEN_W-1:0] len_full;

  logic [HEAD_BYTES-1:0][7:0] head_r;
  logic                       head_we;
  logic [HEAD_IDX_W-1:0]      head_widx;
  logic [HEAD_BYTES-1:0][7:0] hb;

  logic  t_hit, a_hit;
  res_t  t_res, a_res, rep_res, res0, res1;
  logic [1:0] push_cnt;

  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;
  res_t             cur;

  // Payload bytes beyond the frame length read as zero.
  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      hb[i] = (LEN_W'(i) < ack_len_r) ? head_r[i] : 8'h00;
    end
  end

  always_comb begin
    rep_res = '0;
    if (ack_len_r < LEN_W'(2)) begin
      rep_res.kind       = KIND_ACK_SHORT;
      rep_res.ack_length = ack_len_r;
      rep_res.ack_class  = CLS_NO_STATUS;
    end else begin
      rep_res.kind       = KIND_ACK;
      rep_res.ack_length = ack_len_r;
      rep_res.ack_code   = {hb[1], hb[0]};
      for (int k = 0; k < NUM_PW; k++) begin
        rep_res.pw[k] = {hb[3 + 2 * k], hb[2 + 2 * k]};
      end
      priority if (ack_len_r < LEN_W'(4)) begin
        rep_res.ack_class = CLS_NO_STATUS;
      end else if ({hb[1], hb[0]} == ACK_CODE_VERSION) begin
        rep_res.ack_class = CLS_VERSION;
      end else if ({hb[1], hb[0]} == ACK_CODE_ENABLE) begin
        rep_res.ack_class = CLS_ENABLE;
      end else if ({hb[1], hb[0]} == ACK_CODE_END) begin
        rep_res.ack_class = CLS_END;
      end else if ({hb[1], hb[0]} == ACK_CODE_DISTANCE) begin
        rep_res.ack_class = CLS_DISTANCE;
      end else if ({hb[1], hb[0]} == ACK_CODE_READ) begin
        rep_res.ack_class = CLS_READ;
      end else begin
        rep_res.ack_class = CLS_UNKNOWN;
      end
    end
  end

  always_comb begin
    tphase_nxt      = tphase_r;
    held_status_nxt = held_status_r;
    held_dist_nxt   = held_dist_r;
    t_hit           = 1'b0;
    t_res           = '0;
    unique case (tphase_r)
      TP_IDLE: begin
        if (in_byte_r == T_HDR_BYTE) tphase_nxt = TP_HDR2;
      end
      TP_HDR2: begin
        tphase_nxt = (in_byte_r == T_HDR_BYTE) ? TP_STATUS : TP_IDLE;
      end
      TP_STATUS: begin
        held_status_nxt = in_byte_r;
        tphase_nxt      = TP_DLO;
      end
      TP_DLO: begin
        held_dist_nxt = {8'h00, in_byte_r};
        tphase_nxt    = TP_DHI;
      end
      TP_DHI: begin
        held_dist_nxt = {in_byte_r, held_dist_r[7:0]};
        tphase_nxt    = TP_TAIL1;
      end
      TP_TAIL1: begin
        tphase_nxt = (in_byte_r == T_TAIL_BYTE) ? TP_TAIL2 : TP_IDLE;
      end
      TP_TAIL2: begin
        t_hit = 1'b1;
        priority if (in_byte_r != T_TAIL_BYTE) begin
          t_res.kind = KIND_DATA_TAIL;
        end else if (held_status_r > T_MAX_STATUS) begin
          t_res.kind = KIND_BAD_STATUS;
        end else if (held_status_r != 8'h00 && held_dist_r > max_dist_r) begin
          t_res.kind = KIND_TOO_FAR;
        end else begin
          t_res.kind = KIND_TARGET;
        end
        t_res.target_state = held_status_r;
        t_res.target_range = (in_byte_r == T_TAIL_BYTE && held_status_r == 8'h00) ?
                             16'h0000 : held_dist_r;
        tphase_nxt = TP_IDLE;
      end
      default: tphase_nxt = TP_IDLE;
    endcase
  end

  assign idx_inc  = ack_idx_r + IDX_W'(1);
  assign len_full = {in_byte_r, ack_len_r[7:0]};

  always_comb begin
    aphase_nxt  = aphase_r;
    ack_len_nxt = ack_len_r;
    ack_idx_nxt = ack_idx_r;
    head_we     = 1'b0;
    head_widx   = ack_idx_r[HEAD_IDX_W-1:0];
    a_hit       = 1'b0;
    a_res       = '0;
    unique case (aphase_r)
      AP_IDLE: if (in_byte_r == A_HDR1) aphase_nxt = AP_HDR2;
      AP_HDR2: aphase_nxt = (in_byte_r == A_HDR2) ? AP_HDR3 : AP_IDLE;
      AP_HDR3: aphase_nxt = (in_byte_r == A_HDR3) ? AP_HDR4 : AP_IDLE;
      AP_HDR4: aphase_nxt = (in_byte_r == A_HDR4) ? AP_LENL : AP_IDLE;
      AP_LENL: begin
        ack_len_nxt = {8'h00, in_byte_r};
        aphase_nxt  = AP_LENH;
      end
      AP_LENH: begin
        ack_len_nxt = len_full;
        ack_idx_nxt = '0;
        priority if (len_full > LEN_W'(MAX_ACK_BYTES)) begin
          a_hit            = 1'b1;
          a_res.kind       = KIND_ACK_LONG;
          a_res.ack_length = len_full;
          aphase_nxt       = AP_IDLE;
        end else if (len_full == '0) begin
          aphase_nxt = AP_TAIL1;
        end else begin
          aphase_nxt = AP_DATA;
        end
      end
      AP_DATA: begin
        head_we     = (ack_idx_r < IDX_W'(HEAD_BYTES));
        ack_idx_nxt = idx_inc;
        if (LEN_W'(idx_inc) >= ack_len_r) aphase_nxt = AP_TAIL1;
      end
      AP_TAIL1: aphase_nxt = (in_byte_r == A_TAIL1) ? AP_TAIL2 : AP_IDLE;
      AP_TAIL2: aphase_nxt = (in_byte_r == A_TAIL2) ? AP_TAIL3 : AP_IDLE;
      AP_TAIL3: aphase_nxt = (in_byte_r == A_TAIL3) ? AP_TAIL4 : AP_IDLE;
      AP_TAIL4: begin
        a_hit = 1'b1;
        if (in_byte_r == A_TAIL4) begin
          a_res = rep_res;
        end else begin
          a_res.kind       = KIND_ACK_TAIL;
          a_res.ack_length = ack_len_r;
        end
        aphase_nxt = AP_IDLE;
      end
      default: aphase_nxt = AP_IDLE;
    endcase
  end

  always_comb begin
    res0 = t_hit ? t_res : a_res;
    res1 = a_res;
    res0.last = !(t_hit && a_hit);
    res1.last = 1'b1;
    push_cnt = in_vld_r ? (2'(t_hit) + 2'(a_hit)) : 2'd0;
  end

  assign in_tready  = (cnt_r + CNT_W'(push_cnt)) <= CNT_W'(FIFO_DEPTH - 2);
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign cur        = fifo_r[rd_ptr_r];
  assign out_tdata  = {5'd0, cur.pw, cur.ack_class, cur.ack_length, cur.ack_code,
                       cur.target_range, cur.target_state};
  assign out_tlast  = cur.last;
  assign out_tuser  = cur.kind;

  always_ff @(posedge clk) begin
    in_byte_r <= in_tdata;
    if (in_vld_r && head_we) head_r[head_widx] <= in_byte_r;
    if (push_cnt != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      max_dist_r    <= MAX_DIST_RESET;
      tphase_r      <= TP_IDLE;
      aphase_r      <= AP_IDLE;
      held_status_r <= '0;
      held_dist_r   <= '0;
      ack_len_r     <= '0;
      ack_idx_r     <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      in_vld_r <= in_tvalid && in_tready;
      if (cfg_wen) max_dist_r <= cfg_wdata;
      if (in_vld_r) begin
        tphase_r      <= tphase_nxt;
        aphase_r      <= aphase_nxt;
        held_status_r <= held_status_nxt;
        held_dist_r   <= held_dist_nxt;
        ack_len_r     <= ack_len_nxt;
        ack_idx_r     <= ack_idx_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rudfp_checker.sv
`default_nettype none
module rudfp_checker
  import rudfp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast,
  input wire logic [2:0]            out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_target_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_TARGET || out_tuser == KIND_BAD_STATUS ||
    out_tuser == KIND_TOO_FAR || out_tuser == KIND_DATA_TAIL) |->
    out_tdata[138:24] == '0)
    else $error("target result carries acknowledge fields");

  a_ack_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ACK || out_tuser == KIND_ACK_SHORT ||
    out_tuser == KIND_ACK_LONG || out_tuser == KIND_ACK_TAIL) |->
    out_tdata[23:0] == '0 && out_tlast)
    else $error("acknowledge result carries target fields or is not last");

  a_short_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACK_SHORT |->
    out_tdata[58:56] == CLS_NO_STATUS && out_tdata[55:40] < 16'd2)
    else $error("short acknowledge with wrong class or length");

endmodule

bind radar_uart_dual_frame_parser_core rudfp_checker u_rudfp_checker (.*);
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rudfp_pkg::*;

  typedef enum logic [2:0] {
    TS_IDLE, TS_HDR2, TS_STATUS, TS_DLO, TS_DHI, TS_TAIL1, TS_TAIL2
  } tgt_phase_e;

  typedef enum logic [3:0] {
    AS_IDLE, AS_HDR2, AS_HDR3, AS_HDR4, AS_LENL, AS_LENH, AS_DATA,
    AS_TAIL1, AS_TAIL2, AS_TAIL3, AS_TAIL4
  } ack_phase_e;

  typedef struct packed {
    logic [2:0]       kind;
    logic             last;
    logic [7:0]       tstate;
    logic [15:0]      rng;
    logic [15:0]      word;
    logic [15:0]      len;
    logic [2:0]       cls;
    logic [4:0][15:0] pw;
  } frame_report_t;

  typedef struct {
    logic [7:0]    b;
    bit            typed;
    frame_report_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [2:0]            out_tuser;
  logic                  cfg_wen = 1'b0;
  logic [15:0]           cfg_wdata = 16'h0000;

  tgt_phase_e    tgt_phase = TS_IDLE;
  ack_phase_e    ack_phase = AS_IDLE;
  logic [7:0]    tgt_status = 8'h00;
  logic [15:0]   tgt_dist = 16'h0000;
  logic [15:0]   ack_len = 16'h0000;
  logic [15:0]   ack_pos = 16'h0000;
  logic [7:0]    ack_head [HEAD_BYTES];
  logic [15:0]   dist_limit = MAX_DIST_RESET;
  frame_report_t expected_reports [$];
  stim_row_t     directed_rows [$];
  int            errors = 0;
  int            items_sent = 0;
  int            idle_cycles = 0;
  int            stall_left = 0;
  int            last_new = 0;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;

  radar_uart_dual_frame_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic frame_report_t target_report(logic [2:0] kind, logic [7:0] st,
                                                  logic [15:0] rng);
    frame_report_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    r.tstate = st;
    r.rng = rng;
    return r;
  endfunction

  function automatic frame_report_t ack_report(logic [2:0] kind, logic [15:0] word,
                                               logic [15:0] len, logic [2:0] cls);
    frame_report_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    r.word = word;
    r.len = len;
    r.cls = cls;
    return r;
  endfunction

  function automatic logic [7:0] head_byte(int i);
    if (i >= HEAD_BYTES || i >= ack_len) return 8'h00;
    return ack_head[i];
  endfunction

  function automatic logic [15:0] head_word(int i);
    return {head_byte(i + 1), head_byte(i)};
  endfunction

  function automatic frame_report_t ack_summary();
    frame_report_t r;
    r = '0;
    r.len = ack_len;
    if (ack_len < 2) begin
      r.kind = KIND_ACK_SHORT;
      r.cls = CLS_NO_STATUS;
      return r;
    end
    r.kind = KIND_ACK;
    r.word = head_word(0);
    if (ack_len < 4) begin
      r.cls = CLS_NO_STATUS;
    end else begin
      case (r.word)
        ACK_CODE_VERSION:  r.cls = CLS_VERSION;
        ACK_CODE_ENABLE:   r.cls = CLS_ENABLE;
        ACK_CODE_END:      r.cls = CLS_END;
        ACK_CODE_DISTANCE: r.cls = CLS_DISTANCE;
        ACK_CODE_READ:     r.cls = CLS_READ;
        default:           r.cls = CLS_UNKNOWN;
      endcase
    end
    for (int k = 0; k < NUM_PW; k++) r.pw[k] = head_word(2 + 2 * k);
    return r;
  endfunction

  // Both recognizers see every byte; a target report always leaves before an
  // acknowledge report caused by the same byte.
  function automatic void predict_reports(logic [7:0] b);
    frame_report_t rt, ra;
    bit has_t, has_a;
    has_t = 1'b0;
    has_a = 1'b0;
    rt = '0;
    ra = '0;
    case (tgt_phase)
      TS_IDLE:   if (b == T_HDR_BYTE) tgt_phase = TS_HDR2;
      TS_HDR2:   tgt_phase = (b == T_HDR_BYTE) ? TS_STATUS : TS_IDLE;
      TS_STATUS: begin
        tgt_status = b;
        tgt_phase = TS_DLO;
      end
      TS_DLO: begin
        tgt_dist = {8'h00, b};
        tgt_phase = TS_DHI;
      end
      TS_DHI: begin
        tgt_dist[15:8] = b;
        tgt_phase = TS_TAIL1;
      end
      TS_TAIL1:  tgt_phase = (b == T_TAIL_BYTE) ? TS_TAIL2 : TS_IDLE;
      TS_TAIL2: begin
        has_t = 1'b1;
        if (b != T_TAIL_BYTE) rt.kind = KIND_DATA_TAIL;
        else if (tgt_status > T_MAX_STATUS) rt.kind = KIND_BAD_STATUS;
        else if (tgt_status != 8'h00 && tgt_dist > dist_limit) rt.kind = KIND_TOO_FAR;
        else rt.kind = KIND_TARGET;
        rt.tstate = tgt_status;
        rt.rng = (b == T_TAIL_BYTE && tgt_status == 8'h00) ? 16'h0000 : tgt_dist;
        tgt_phase = TS_IDLE;
      end
      default:   tgt_phase = TS_IDLE;
    endcase
    case (ack_phase)
      AS_IDLE:  if (b == A_HDR1) ack_phase = AS_HDR2;
      AS_HDR2:  ack_phase = (b == A_HDR2) ? AS_HDR3 : AS_IDLE;
      AS_HDR3:  ack_phase = (b == A_HDR3) ? AS_HDR4 : AS_IDLE;
      AS_HDR4:  ack_phase = (b == A_HDR4) ? AS_LENL : AS_IDLE;
      AS_LENL: begin
        ack_len = {8'h00, b};
        ack_phase = AS_LENH;
      end
      AS_LENH: begin
        ack_len[15:8] = b;
        ack_pos = 16'h0000;
        if (ack_len > MAX_ACK_BYTES) begin
          has_a = 1'b1;
          ra.kind = KIND_ACK_LONG;
          ra.len = ack_len;
          ack_phase = AS_IDLE;
        end else if (ack_len == 16'h0000) begin
          ack_phase = AS_TAIL1;
        end else begin
          ack_phase = AS_DATA;
        end
      end
      AS_DATA: begin
        if (ack_pos < HEAD_BYTES) ack_head[ack_pos] = b;
        ack_pos++;
        if (ack_pos >= ack_len) ack_phase = AS_TAIL1;
      end
      AS_TAIL1: ack_phase = (b == A_TAIL1) ? AS_TAIL2 : AS_IDLE;
      AS_TAIL2: ack_phase = (b == A_TAIL2) ? AS_TAIL3 : AS_IDLE;
      AS_TAIL3: ack_phase = (b == A_TAIL3) ? AS_TAIL4 : AS_IDLE;
      AS_TAIL4: begin
        has_a = 1'b1;
        if (b == A_TAIL4) begin
          ra = ack_summary();
        end else begin
          ra.kind = KIND_ACK_TAIL;
          ra.len = ack_len;
        end
        ack_phase = AS_IDLE;
      end
      default:  ack_phase = AS_IDLE;
    endcase
    if (has_a) ra.last = 1'b1;
    else if (has_t) rt.last = 1'b1;
    if (has_t) expected_reports.push_back(rt);
    if (has_a) expected_reports.push_back(ra);
    last_new = int'(has_t) + int'(has_a);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report();
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      $error("result with no expectation waiting: kind %0d", out_tuser);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    check_field("kind", 16'(want.kind), 16'(out_tuser));
    check_field("last", 16'(want.last), 16'(out_tlast));
    check_field("target_state", 16'(want.tstate), 16'(out_tdata[7:0]));
    check_field("target_range", want.rng, out_tdata[23:8]);
    check_field("ack_code", want.word, out_tdata[39:24]);
    check_field("ack_length", want.len, out_tdata[55:40]);
    check_field("ack_class", 16'(want.cls), 16'(out_tdata[58:56]));
    for (int k = 0; k < NUM_PW; k++)
      check_field($sformatf("payload_word%0d", k), want.pw[k], out_tdata[59 + 16 * k +: 16]);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report();
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 399;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == 3000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic feed(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predict_reports(b);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic add_frame(input logic [7:0] bytes [$], input bit typed,
                           input frame_report_t want);
    foreach (bytes[k])
      directed_rows.push_back('{bytes[k], typed && k == bytes.size() - 1, want});
  endtask

  task automatic send_random_sequence();
    logic [7:0] frame [$];
    logic [7:0] st;
    logic [15:0] d, len, word;
    int bad_at;
    frame = {};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 7))
          0:       st = 8'h00;
          1, 2:    st = 8'h01;
          3, 4:    st = 8'h02;
          5:       st = 8'($urandom_range(3, 255));
          default: st = 8'($urandom_range(0, 2));
        endcase
        case ($urandom_range(0, 5))
          0:       d = dist_limit;
          1:       d = dist_limit + 16'd1;
          2:       d = dist_limit - 16'd1;
          3:       d = 16'h0000;
          4:       d = 16'hFFFF;
          default: d = 16'($urandom);
        endcase
        frame = {T_HDR_BYTE, T_HDR_BYTE, st, d[7:0], d[15:8], T_TAIL_BYTE, T_TAIL_BYTE};
        bad_at = $urandom_range(0, 9);
        if (bad_at < 2) frame[5 + bad_at] = 8'($urandom);
      end
      4, 5, 6: begin
        case ($urandom_range(0, 9))
          0:       len = 16'd0;
          1:       len = 16'd1;
          2, 3:    len = 16'($urandom_range(2, 3));
          4, 5, 6: len = 16'($urandom_range(4, HEAD_BYTES));
          7:       len = 16'($urandom_range(HEAD_BYTES + 1, MAX_ACK_BYTES));
          8:       len = 16'($urandom_range(MAX_ACK_BYTES, MAX_ACK_BYTES + 1));
          default: len = 16'($urandom_range(MAX_ACK_BYTES + 1, 65535));
        endcase
        case ($urandom_range(0, 6))
          0:       word = ACK_CODE_VERSION;
          1:       word = ACK_CODE_ENABLE;
          2:       word = ACK_CODE_END;
          3:       word = ACK_CODE_DISTANCE;
          4:       word = ACK_CODE_READ;
          default: word = 16'($urandom);
        endcase
        frame = {A_HDR1, A_HDR2, A_HDR3, A_HDR4, len[7:0], len[15:8]};
        if (len <= MAX_ACK_BYTES) begin
          for (int k = 0; k < len; k++) begin
            if (k == 0) frame.push_back(word[7:0]);
            else if (k == 1) frame.push_back(word[15:8]);
            else frame.push_back(8'($urandom));
          end
          frame.push_back(A_TAIL1);
          frame.push_back(A_TAIL2);
          frame.push_back(A_TAIL3);
          frame.push_back(A_TAIL4);
          bad_at = $urandom_range(0, 11);
          if (bad_at < 4) frame[frame.size() - 4 + bad_at] = 8'($urandom);
        end
      end
      7: begin
        case ($urandom_range(0, 3))
          0:       frame = {T_HDR_BYTE, 8'($urandom)};
          1:       frame = {A_HDR1, 8'($urandom)};
          2:       frame = {A_HDR1, A_HDR2, 8'($urandom)};
          default: frame = {A_HDR1, A_HDR2, A_HDR3, 8'($urandom)};
        endcase
      end
      default: repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
    endcase
    foreach (frame[k]) feed(frame[k]);
  endtask

  initial begin : main
    logic [15:0] limits [6];
    int phase_end;
    bit paused;
    limits = '{16'd0, 16'hFFFF, 16'd1000, 16'h0000, 16'd300, MAX_DIST_RESET};
    limits[3] = 16'($urandom);
    paused = 1'b0;

    add_frame({T_HDR_BYTE, T_HDR_BYTE, 8'h00, 8'h34, 8'h12, T_TAIL_BYTE, T_TAIL_BYTE}, 1'b1,
              target_report(KIND_TARGET, 8'h00, 16'h0000));
    add_frame({T_HDR_BYTE, T_HDR_BYTE, 8'h07, 8'hFF, 8'hFF, T_TAIL_BYTE, T_TAIL_BYTE}, 1'b1,
              target_report(KIND_BAD_STATUS, 8'h07, 16'hFFFF));
    add_frame({T_HDR_BYTE, T_HDR_BYTE, 8'h01, 8'h21, 8'h03, T_TAIL_BYTE, T_TAIL_BYTE}, 1'b1,
              target_report(KIND_TOO_FAR, 8'h01, 16'h0321));
    add_frame({A_HDR1, A_HDR2, A_HDR3, A_HDR4, 8'h00, 8'h01}, 1'b1,
              ack_report(KIND_ACK_LONG, '0, 16'h0100, '0));
    add_frame({A_HDR1, A_HDR2, A_HDR3, A_HDR4, 8'h02, 8'h00, 8'h01, 8'hFF,
               A_TAIL1, A_TAIL2, A_TAIL3, A_TAIL4}, 1'b1,
              ack_report(KIND_ACK, ACK_CODE_ENABLE, 16'h0002, CLS_NO_STATUS));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      feed(directed_rows[i].b);
      if (directed_rows[i].typed) begin
        repeat (last_new) void'(expected_reports.pop_back());
        expected_reports.push_back(directed_rows[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      cfg_wen <= 1'b1;
      cfg_wdata <= limits[p];
      @(posedge clk);
      cfg_wen <= 1'b0;
      dist_limit = limits[p];
      quiet = (p == 5);
      if (p == 1) hold_req = 1'b1;
      phase_end = items_sent + 120;
      while (items_sent < phase_end) begin
        if (p == 3 && !paused && items_sent >= phase_end - 60) begin
          paused = 1'b1;
          wait_drained();
        end
        send_random_sequence();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
